// ----- src/rmsd_pkg.sv -----
// Shared widths, limits and control types for the RMSD core.
// No dependencies; imported by every module of the block.
`default_nettype none

package rmsd_pkg;

  localparam int SUM_W     = 62;  // squared-distance sum, 20 fraction bits
  localparam int DEV_W     = 25;  // deviation output, 10 fraction bits
  localparam int CNT_OUT_W = 11;  // reported pair count
  localparam int ROOT_W    = SUM_W / 2;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [DEV_W-1:0] DEV_MAX = '1;

  // Control from the sequencer to the squared-distance accumulator
  typedef struct packed {
    logic start;  // latch coordinates and run one pair
    logic clear;  // zero the running sum
  } acc_ctrl_t;

endpackage

`default_nettype wire

// ----- src/rmsd_sqacc.sv -----
// Squared-distance accumulator: one shared subtract/multiply/add path used
// once per axis, adding the squared distance of a point pair to the sum.
// Depends on rmsd_pkg.
`default_nettype none

module rmsd_sqacc #(
  parameter int COORD_BITS = 24
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire rmsd_pkg::acc_ctrl_t     ctrl,
  input  wire signed [COORD_BITS-1:0]  ref_x,
  input  wire signed [COORD_BITS-1:0]  ref_y,
  input  wire signed [COORD_BITS-1:0]  ref_z,
  input  wire signed [COORD_BITS-1:0]  pos_x,
  input  wire signed [COORD_BITS-1:0]  pos_y,
  input  wire signed [COORD_BITS-1:0]  pos_z,
  output logic [rmsd_pkg::SUM_W-1:0]   square_sum,
  output logic                         done
);
  import rmsd_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int AW = ((PW > SUM_W) ? PW : SUM_W) + 1;
  localparam logic [2:0] LAST_STEP = 3'd4;

  logic signed [COORD_BITS-1:0] rx, ry, rz, px, py, pz;
  logic signed [COORD_BITS-1:0] ref_sel, pos_sel;
  logic signed [DW-1:0]         diff;
  logic [DW-1:0]                mag;
  logic [DW-1:0]                mag_q;
  logic [PW-1:0]                prod_next;
  logic [PW-1:0]                prod_q;
  logic [AW-1:0]                total;
  logic [SUM_W-1:0]             square_sum_next;
  logic                         active;
  logic [2:0]                   step;

  // step n loads axis n, squares axis n-1, adds axis n-2
  always_comb begin
    case (step)
      3'd0:    begin ref_sel = rx; pos_sel = px; end
      3'd1:    begin ref_sel = ry; pos_sel = py; end
      default: begin ref_sel = rz; pos_sel = pz; end
    endcase
  end

  assign diff      = DW'(pos_sel) - DW'(ref_sel);
  assign mag       = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign prod_next = PW'(mag_q) * PW'(mag_q);
  assign total     = AW'(square_sum) + AW'(prod_q);
  assign square_sum_next = (total > AW'(SUM_MAX)) ? SUM_MAX : total[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      step       <= '0;
      done       <= 1'b0;
      square_sum <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        active <= 1'b1;
        step   <= '0;
      end else if (active) begin
        if (step >= 3'd2) begin
          square_sum <= square_sum_next;
        end
        if (step == LAST_STEP) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          step <= step + 3'd1;
        end
      end else if (ctrl.clear) begin
        square_sum <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rx <= ref_x; ry <= ref_y; rz <= ref_z;
      px <= pos_x; py <= pos_y; pz <= pos_z;
    end
    if (active && step < 3'd3) begin
      mag_q <= mag;
    end
    if (active && step >= 3'd1 && step <= 3'd3) begin
      prod_q <= prod_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/rmsd_divsqrt.sv -----
// Shared compare/subtract unit: restoring division of the sum by the pair
// count, one quotient bit a cycle, then digit-by-digit square root of the
// quotient, one root bit a cycle. Depends on rmsd_pkg.
`default_nettype none

module rmsd_divsqrt #(
  parameter int CW = 11
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  input  wire [rmsd_pkg::SUM_W-1:0]   dividend,
  input  wire [CW-1:0]                divisor,
  output logic [rmsd_pkg::ROOT_W-1:0] root,
  output logic                        done
);
  import rmsd_pkg::*;

  localparam int SW     = ((CW + 1) > (ROOT_W + 3)) ? (CW + 1) : (ROOT_W + 3);
  localparam int ITER_W = $clog2(SUM_W);

  typedef enum logic [1:0] {
    M_IDLE,
    M_DIV,
    M_SQRT
  } mode_t;

  mode_t             mode;
  logic [SUM_W-1:0]  work;
  logic [SW-1:0]     rem;
  logic [CW-1:0]     dvsr;
  logic [ITER_W-1:0] iter;
  logic [SW-1:0]     shifted;
  logic [SW-1:0]     trial;
  logic [SW:0]       delta;
  logic              ge;

  always_comb begin
    if (mode == M_SQRT) begin
      shifted = {rem[SW-3:0], work[SUM_W-1 -: 2]};
      trial   = {{(SW-ROOT_W-2){1'b0}}, root, 2'b01};
    end else begin
      shifted = {rem[SW-2:0], work[SUM_W-1]};
      trial   = {{(SW-CW){1'b0}}, dvsr};
    end
  end

  assign delta = {1'b0, shifted} - {1'b0, trial};
  assign ge    = ~delta[SW];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      iter <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (mode)
        M_IDLE: begin
          if (start) begin
            mode <= M_DIV;
            iter <= '0;
          end
        end
        M_DIV: begin
          if (iter == ITER_W'(SUM_W - 1)) begin
            mode <= M_SQRT;
            iter <= '0;
          end else begin
            iter <= iter + ITER_W'(1);
          end
        end
        M_SQRT: begin
          if (iter == ITER_W'(ROOT_W - 1)) begin
            mode <= M_IDLE;
            done <= 1'b1;
          end else begin
            iter <= iter + ITER_W'(1);
          end
        end
        default: mode <= M_IDLE;
      endcase
    end
  end

  // datapath; the quotient replaces the dividend in work, bit by bit
  always_ff @(posedge clk) begin
    case (mode)
      M_IDLE: begin
        if (start) begin
          work <= dividend;
          dvsr <= divisor;
          rem  <= '0;
        end
      end
      M_DIV: begin
        work <= {work[SUM_W-2:0], ge};
        if (iter == ITER_W'(SUM_W - 1)) begin
          rem  <= '0;
          root <= '0;
        end else begin
          rem <= ge ? delta[SW-1:0] : shifted;
        end
      end
      M_SQRT: begin
        work <= {work[SUM_W-3:0], 2'b00};
        rem  <= ge ? delta[SW-1:0] : shifted;
        root <= {root[ROOT_W-2:0], ge};
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/coordinate_rmsd_core.sv -----
// RMSD core: root mean square deviation over a set of paired 3D points.
// Input channel item_valid/item_ready carries one reference point and one
// test point (signed, 10 fraction bits) plus last_pair. Output channel
// result_valid/result_ready carries deviation, pair_count and overflowed,
// one result per set, started by the transfer of the pair marked last.
// A pair that is counted runs through the squared-distance unit (one
// subtract, one multiply and one add per axis through a three-stage path);
// item_ready is low meanwhile. A pair arriving with the count already at
// MAX_ATOMS only sets the overflow flag and is not accumulated.
// On the last pair the shared compare/subtract unit runs 62 division steps
// and 31 square-root steps; the result then goes to an output register.
// The next set is accepted while a result waits in that register. If the
// receiver stalls with a result still held when the next one is ready, the
// core waits with item_ready low.
// Synchronous reset clears the sum, the count, the overflow flag and the
// output valid; no clearing pass is needed.
// Depends on rmsd_pkg, rmsd_sqacc, rmsd_divsqrt.
`default_nettype none

module coordinate_rmsd_core #(
  parameter int MAX_ATOMS  = 1024,
  parameter int COORD_BITS = 24
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              item_valid,
  output logic                             item_ready,
  input  wire signed [COORD_BITS-1:0]      ref_x,
  input  wire signed [COORD_BITS-1:0]      ref_y,
  input  wire signed [COORD_BITS-1:0]      ref_z,
  input  wire signed [COORD_BITS-1:0]      pos_x,
  input  wire signed [COORD_BITS-1:0]      pos_y,
  input  wire signed [COORD_BITS-1:0]      pos_z,
  input  wire                              last_pair,
  output logic                             result_valid,
  input  wire                              result_ready,
  output logic [rmsd_pkg::DEV_W-1:0]       deviation,
  output logic [rmsd_pkg::CNT_OUT_W-1:0]   pair_count,
  output logic                             overflowed
);
  import rmsd_pkg::*;

  localparam int CW = $clog2(MAX_ATOMS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ATOMS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIV,
    ST_HOLD
  } state_t;

  state_t              state;
  logic [CW-1:0]       pairs_seen;
  logic                count_overflow;
  logic                last_q;
  logic                accept;
  logic                full;
  acc_ctrl_t           acc_ctrl;
  logic [SUM_W-1:0]    square_sum;
  logic                acc_done;
  logic                ds_start;
  logic [ROOT_W-1:0]   root;
  logic                ds_done;
  logic                out_free;
  logic [CW+CNT_OUT_W-1:0] count_ext;
  logic [DEV_W-1:0]    deviation_next;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign full       = (pairs_seen == MAX_CNT);
  assign out_free   = !result_valid || result_ready;

  assign acc_ctrl.start = accept && !full;
  assign acc_ctrl.clear = (state == ST_HOLD) && out_free;
  assign ds_start = (accept && full && last_pair) ||
                    ((state == ST_ACCUM) && acc_done && last_q);

  assign count_ext      = {{CNT_OUT_W{1'b0}}, pairs_seen};
  assign deviation_next = (|root[ROOT_W-1:DEV_W]) ? DEV_MAX : root[DEV_W-1:0];

  rmsd_sqacc #(
    .COORD_BITS(COORD_BITS)
  ) u_sqacc (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (acc_ctrl),
    .ref_x      (ref_x),
    .ref_y      (ref_y),
    .ref_z      (ref_z),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .square_sum (square_sum),
    .done       (acc_done)
  );

  rmsd_divsqrt #(
    .CW(CW)
  ) u_divsqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (ds_start),
    .dividend (square_sum),
    .divisor  (pairs_seen),
    .root     (root),
    .done     (ds_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      pairs_seen     <= '0;
      count_overflow <= 1'b0;
      last_q         <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (state == ST_HOLD && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            last_q <= last_pair;
            if (full) begin
              count_overflow <= 1'b1;
              if (last_pair) begin
                state <= ST_DIV;
              end
            end else begin
              pairs_seen <= pairs_seen + CW'(1);
              state      <= ST_ACCUM;
            end
          end
        end
        ST_ACCUM: begin
          if (acc_done) begin
            state <= last_q ? ST_DIV : ST_IDLE;
          end
        end
        ST_DIV: begin
          if (ds_done) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            deviation      <= deviation_next;
            pair_count     <= count_ext[CNT_OUT_W-1:0];
            overflowed     <= count_overflow;
            pairs_seen     <= '0;
            count_overflow <= 1'b0;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pairs_seen <= MAX_CNT)
    else $error("pair count beyond limit");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    count_overflow |-> full)
    else $error("overflow flag set with count below limit");

  a_acc_done_state: assert property (@(posedge clk) disable iff (rst)
    acc_done |-> state == ST_ACCUM)
    else $error("accumulator finished outside accumulate state");

  a_ds_done_state: assert property (@(posedge clk) disable iff (rst)
    ds_done |-> state == ST_DIV)
    else $error("divide/sqrt finished outside divide state");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD && out_free) |=> result_valid && pairs_seen == '0)
    else $error("result load did not clear the set");

endmodule

`default_nettype wire
